// ----- rtl/lab_pkg.sv -----
// Shared types and constants for the line and arc bounding box block.
package lab_pkg;

    localparam logic [1:0] CMD_LINE = 2'd0;
    localparam logic [1:0] CMD_ARC  = 2'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the word and clear the box if asked
        logic take_line;  // take both endpoints of a line
        logic take_start; // take arc start point
        logic sq0;        // load radicand for start radius
        logic sq1;        // load radicand for end radius
        logic mul_x;      // form |d1x| * r
        logic mul_y;      // form |d1y| * r
        logic div_x;      // start division for x
        logic div_y;      // start division for y
        logic take_end;   // take scaled end point
        logic take_axes;  // take axis extreme points on the arc
        logic publish;    // register the result word
    } lab_cmd_t;

    typedef struct packed {
        logic unit_done;  // shared sqrt or divide unit finished
        logic r_zero;     // start radius is zero
        logic r1_zero;    // end radius is zero
        logic [1:0] command;
    } lab_status_t;

endpackage

// ----- rtl/lab_datapath.sv -----
// Datapath: box registers, radius and scaling arithmetic, iterative root/divide unit.
module lab_datapath #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lab_pkg::lab_cmd_t              cmd,
    output lab_pkg::lab_status_t           status,
    input  logic [1:0]                     command,
    input  logic                           first_edge,
    input  logic signed [COORD_WIDTH-1:0]  start_x,
    input  logic signed [COORD_WIDTH-1:0]  start_y,
    input  logic signed [COORD_WIDTH-1:0]  end_x,
    input  logic signed [COORD_WIDTH-1:0]  end_y,
    input  logic signed [COORD_WIDTH-1:0]  center_x,
    input  logic signed [COORD_WIDTH-1:0]  center_y,
    input  logic                           second_is_cw_start,
    output logic [COORD_WIDTH-1:0]         width,
    output logic [COORD_WIDTH-1:0]         height,
    output logic signed [COORD_WIDTH-1:0]  box_min_x,
    output logic signed [COORD_WIDTH-1:0]  box_min_y,
    output logic                           box_valid
);
    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;        // offsets from the centre
    localparam int RW = CW + 1;        // radius width
    localparam int SW = 2 * DW;        // squared length, an even number of bits
    localparam int PW = DW + RW;       // magnitude times radius
    localparam int IW = $clog2(RW + 1);
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW+1:0] CMAX_W = {3'b000, {(CW-1){1'b1}}};
    localparam logic signed [CW+1:0] CMIN_W = {3'b111, {(CW-1){1'b0}}};

    logic [1:0]  command_reg;
    logic signed [CW-1:0] sx_reg, sy_reg, ex_reg, ey_reg, cx_reg, cy_reg;
    logic signed [DW-1:0] d0x_reg, d0y_reg, d1x_reg, d1y_reg;
    logic signed [CW-1:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic seen_reg;
    logic [RW-1:0] r_reg, r1_reg;
    logic [PW-1:0] prod_reg;
    logic [RW-1:0] qx_reg;
    logic [CW-1:0] width_reg, height_reg;
    logic signed [CW-1:0] omin_x_reg, omin_y_reg;
    logic ovalid_reg;

    // Shared unit: restoring square root or restoring division, one bit a cycle.
    logic          unit_busy_reg, unit_div_reg, unit_done_reg;
    logic [IW-1:0] unit_cnt_reg;
    logic [SW-1:0] rem_reg;         // sqrt remainder
    logic [SW-1:0] rad_reg;         // sqrt radicand, shifted two bits a cycle
    logic [RW-1:0] root_reg;
    logic [PW:0]   drem_reg;
    logic [PW-1:0] dnum_reg;
    logic [RW-1:0] dquo_reg;
    logic          unit_dst_reg;    // 0: r, 1: r1 for sqrt

    // Offsets and squares.
    logic [DW-1:0] mag0x, mag0y, mag1x, mag1y;
    assign mag0x = d0x_reg[DW-1] ? DW'(-d0x_reg) : DW'(d0x_reg);
    assign mag0y = d0y_reg[DW-1] ? DW'(-d0y_reg) : DW'(d0y_reg);
    assign mag1x = d1x_reg[DW-1] ? DW'(-d1x_reg) : DW'(d1x_reg);
    assign mag1y = d1y_reg[DW-1] ? DW'(-d1y_reg) : DW'(d1y_reg);

    // One multiplier, time shared; the x and y squares are formed in turn and summed.
    logic [DW-1:0] mul_a, mul_b;
    logic [2*DW-1:0] mul_p;
    logic [1:0] sq_phase_reg;
    logic [SW-1:0] sq_acc_reg;

    always_comb
    begin
        mul_a = mag0x;
        mul_b = mag0x;
        if (cmd.mul_x)
        begin
            mul_a = mag1x;
            mul_b = DW'(r_reg);
        end
        else if (cmd.mul_y)
        begin
            mul_a = mag1y;
            mul_b = DW'(r_reg);
        end
        else if (sq_phase_reg == 2'd1)
        begin
            mul_a = unit_dst_reg ? mag1y : mag0y;
            mul_b = mul_a;
        end
        else if (cmd.sq1)
        begin
            mul_a = mag1x;
            mul_b = mag1x;
        end
    end
    assign mul_p = mul_a * mul_b;

    // Saturating take of a point, widened by two bits.
    function automatic logic signed [CW-1:0] sat_w(input logic signed [CW+1:0] v);
        if (v > CMAX_W)
            sat_w = CMAX;
        else if (v < CMIN_W)
            sat_w = CMIN;
        else
            sat_w = v[CW-1:0];
    endfunction

    // Candidate points of this cycle: up to four (axis step takes all four).
    logic signed [CW+1:0] px [4];
    logic signed [CW+1:0] py [4];
    logic                 pv [4];

    // Angular class logic for the axis test.
    // Cross and dot signs with axis directions need only component signs.
    function automatic logic [1:0] cls_axis(input logic signed [DW-1:0] ax,
                                            input logic signed [DW-1:0] ay,
                                            input int k);
        logic signed [DW:0] cr, dt;
        begin
            case (k)
                0: begin cr = -(DW+1)'(ay); dt = (DW+1)'(ax); end
                1: begin cr = (DW+1)'(ax);  dt = (DW+1)'(ay); end
                2: begin cr = (DW+1)'(ay);  dt = -(DW+1)'(ax); end
                default: begin cr = -(DW+1)'(ax); dt = -(DW+1)'(ay); end
            endcase
            if (cr > 0)
                cls_axis = 2'd1;
            else if (cr < 0)
                cls_axis = 2'd3;
            else if (dt > 0)
                cls_axis = 2'd0;
            else
                cls_axis = 2'd2;
        end
    endfunction

    // Class of end direction against start.
    logic [1:0] c1_reg;

    logic signed [CW+1:0] rr;
    logic signed [CW+1:0] scx, scy, qxs, qys;
    logic [1:0] cu [4];
    logic       on_arc [4];
    logic signed [DW:0] ux_d1y, uy_d1x;

    always_comb
    begin
        rr  = (CW+2)'(r_reg);
        scx = (CW+2)'(cx_reg);
        scy = (CW+2)'(cy_reg);
        qxs = d1x_reg[DW-1] ? -(CW+2)'(qx_reg) : (CW+2)'(qx_reg);
        qys = d1y_reg[DW-1] ? -(CW+2)'(dquo_reg) : (CW+2)'(dquo_reg);
        for (int k = 0; k < 4; k++)
        begin
            px[k] = '0;
            py[k] = '0;
            pv[k] = 1'b0;
            cu[k] = cls_axis(d0x_reg, d0y_reg, k);
            case (k)
                0: begin ux_d1y = (DW+1)'(d1y_reg);  uy_d1x = '0; end
                1: begin ux_d1y = '0; uy_d1x = (DW+1)'(d1x_reg); end
                2: begin ux_d1y = -(DW+1)'(d1y_reg); uy_d1x = '0; end
                default: begin ux_d1y = '0; uy_d1x = -(DW+1)'(d1x_reg); end
            endcase
            if (c1_reg == 2'd0 || cu[k] == 2'd0 || cu[k] < c1_reg)
                on_arc[k] = 1'b1;
            else if (cu[k] > c1_reg)
                on_arc[k] = 1'b0;
            else if (cu[k] == 2'd2)
                on_arc[k] = 1'b1;
            else
                on_arc[k] = (ux_d1y - uy_d1x) >= 0;
        end
        if (cmd.take_line)
        begin
            px[0] = (CW+2)'(sx_reg); py[0] = (CW+2)'(sy_reg); pv[0] = 1'b1;
            px[1] = (CW+2)'(ex_reg); py[1] = (CW+2)'(ey_reg); pv[1] = 1'b1;
        end
        else if (cmd.take_start)
        begin
            px[0] = (CW+2)'(sx_reg); py[0] = (CW+2)'(sy_reg); pv[0] = 1'b1;
        end
        else if (cmd.take_end)
        begin
            px[0] = scx + qxs; py[0] = scy + qys; pv[0] = 1'b1;
        end
        else if (cmd.take_axes)
        begin
            px[0] = scx + rr; py[0] = scy;      pv[0] = on_arc[0];
            px[1] = scx;      py[1] = scy + rr; pv[1] = on_arc[1];
            px[2] = scx - rr; py[2] = scy;      pv[2] = on_arc[2];
            px[3] = scx;      py[3] = scy - rr; pv[3] = on_arc[3];
        end
    end

    logic signed [CW-1:0] nmin_x, nmin_y, nmax_x, nmax_y;
    logic nseen;
    logic signed [CW-1:0] tx, ty;
    always_comb
    begin
        nmin_x = min_x_reg; nmin_y = min_y_reg;
        nmax_x = max_x_reg; nmax_y = max_y_reg;
        nseen = seen_reg;
        tx = '0;
        ty = '0;
        for (int k = 0; k < 4; k++)
        begin
            tx = sat_w(px[k]);
            ty = sat_w(py[k]);
            if (pv[k])
            begin
                if (tx < nmin_x) nmin_x = tx;
                if (tx > nmax_x) nmax_x = tx;
                if (ty < nmin_y) nmin_y = ty;
                if (ty > nmax_y) nmax_y = ty;
                nseen = 1'b1;
            end
        end
    end

    // Exact cross and dot of d0 and d1 from one signed multiplier, four products in turn.
    logic [1:0] cls_phase_reg;
    logic signed [2*DW-1:0] hold_reg;
    logic signed [2*DW-1:0] cross_reg;
    logic signed [DW-1:0] smul_a, smul_b;
    logic signed [2*DW-1:0] smul_p;

    always_comb
    begin
        case (cls_phase_reg)
            2'd1: begin smul_a = d0x_reg; smul_b = d1y_reg; end
            2'd2: begin smul_a = d0y_reg; smul_b = d1x_reg; end
            2'd3: begin smul_a = d0x_reg; smul_b = d1x_reg; end
            default: begin smul_a = d0y_reg; smul_b = d1y_reg; end
        endcase
    end
    assign smul_p = smul_a * smul_b;

    // Square root step.
    logic [SW-1:0] sq_trial;
    logic [SW-1:0] sq_rem_sh;
    assign sq_rem_sh = {rem_reg[SW-3:0], rad_reg[SW-1:SW-2]};
    assign sq_trial  = {root_reg[RW-2:0], 2'b01} & SW'({(RW+1){1'b1}});
    // Divide step.
    logic [PW:0] d_sh;
    assign d_sh = {drem_reg[PW-1:0], dnum_reg[PW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= CMAX; min_y_reg <= CMAX;
            max_x_reg <= CMIN; max_y_reg <= CMIN;
            seen_reg <= 1'b0;
            unit_busy_reg <= 1'b0;
            unit_done_reg <= 1'b0;
            sq_phase_reg <= '0;
            cls_phase_reg <= '0;
            ovalid_reg <= 1'b0;
            omin_x_reg <= CMAX;
            omin_y_reg <= CMAX;
            width_reg <= '0;
            height_reg <= '0;
        end
        else
        begin
            unit_done_reg <= 1'b0;
            if (cmd.load)
            begin
                command_reg <= command;
                if (command == lab_pkg::CMD_ARC && !second_is_cw_start)
                begin
                    sx_reg <= end_x; sy_reg <= end_y; ex_reg <= start_x; ey_reg <= start_y;
                    d0x_reg <= DW'(end_x) - DW'(center_x);
                    d0y_reg <= DW'(end_y) - DW'(center_y);
                    d1x_reg <= DW'(start_x) - DW'(center_x);
                    d1y_reg <= DW'(start_y) - DW'(center_y);
                end
                else
                begin
                    sx_reg <= start_x; sy_reg <= start_y; ex_reg <= end_x; ey_reg <= end_y;
                    d0x_reg <= DW'(start_x) - DW'(center_x);
                    d0y_reg <= DW'(start_y) - DW'(center_y);
                    d1x_reg <= DW'(end_x) - DW'(center_x);
                    d1y_reg <= DW'(end_y) - DW'(center_y);
                end
                cx_reg <= center_x;
                cy_reg <= center_y;
                if (first_edge)
                begin
                    min_x_reg <= CMAX; min_y_reg <= CMAX;
                    max_x_reg <= CMIN; max_y_reg <= CMIN;
                    seen_reg <= 1'b0;
                end
            end
            else
            begin
                min_x_reg <= nmin_x; min_y_reg <= nmin_y;
                max_x_reg <= nmax_x; max_y_reg <= nmax_y;
                seen_reg <= nseen;
            end

            // Squared length from the x and y squares, then the root.
            if (cmd.sq0 || cmd.sq1)
            begin
                sq_acc_reg <= SW'(mul_p);
                sq_phase_reg <= 2'd1;
                unit_dst_reg <= cmd.sq1;
                cls_phase_reg <= 2'd1;
            end
            else if (sq_phase_reg == 2'd1)
            begin
                rad_reg <= sq_acc_reg + SW'(mul_p);
                rem_reg <= '0;
                root_reg <= '0;
                unit_cnt_reg <= IW'(RW);
                unit_busy_reg <= 1'b1;
                unit_div_reg <= 1'b0;
                sq_phase_reg <= 2'd0;
            end

            // Class of end direction: cross then dot, signed multiplies.
            case (cls_phase_reg)
                2'd1:
                begin
                    hold_reg <= smul_p;
                    cls_phase_reg <= 2'd2;
                end
                2'd2:
                begin
                    cross_reg <= hold_reg - smul_p;
                    cls_phase_reg <= 2'd3;
                end
                2'd3:
                begin
                    hold_reg <= smul_p;
                    cls_phase_reg <= 2'd0;
                end
                default:
                begin
                end
            endcase

            if (cmd.mul_x || cmd.mul_y)
                prod_reg <= PW'(mul_p);
            if (cmd.div_x || cmd.div_y)
            begin
                dquo_reg <= '0;
                unit_cnt_reg <= IW'(PW > RW ? RW : PW);
                unit_busy_reg <= 1'b1;
                unit_div_reg <= 1'b1;
                // Quotient fits the radius width: shift out the top bits first.
                drem_reg <= (PW+1)'(prod_reg >> RW);
                dnum_reg <= prod_reg << (PW - RW);
                if (cmd.div_y)
                    qx_reg <= dquo_reg;
            end
            else if (unit_busy_reg)
            begin
                if (unit_div_reg)
                begin
                    if (d_sh >= (PW+1)'(r1_reg))
                    begin
                        drem_reg <= d_sh - (PW+1)'(r1_reg);
                        dquo_reg <= {dquo_reg[RW-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= d_sh;
                        dquo_reg <= {dquo_reg[RW-2:0], 1'b0};
                    end
                    dnum_reg <= dnum_reg << 1;
                end
                else
                begin
                    rad_reg <= rad_reg << 2;
                    if (sq_rem_sh >= sq_trial)
                    begin
                        rem_reg <= sq_rem_sh - sq_trial;
                        root_reg <= {root_reg[RW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= sq_rem_sh;
                        root_reg <= {root_reg[RW-2:0], 1'b0};
                    end
                end
                unit_cnt_reg <= unit_cnt_reg - IW'(1);
                if (unit_cnt_reg == IW'(1))
                begin
                    unit_busy_reg <= 1'b0;
                    unit_done_reg <= 1'b1;
                end
            end
            if (unit_done_reg && !unit_div_reg)
            begin
                if (unit_dst_reg)
                    r1_reg <= root_reg;
                else
                    r_reg <= root_reg;
            end

            if (cmd.publish)
            begin
                width_reg  <= seen_reg ? CW'(max_x_reg - min_x_reg) : '0;
                height_reg <= seen_reg ? CW'(max_y_reg - min_y_reg) : '0;
                omin_x_reg <= min_x_reg;
                omin_y_reg <= min_y_reg;
                ovalid_reg <= seen_reg;
            end
        end
    end

    // Class of d1 against d0 from the staged cross and dot products.
    // An end point on the centre takes the start direction, which is class 0.
    logic signed [2*DW-1:0] dot_full;
    assign dot_full = hold_reg + smul_p;
    always_ff @(posedge clk)
    begin
        if (cmd.take_end || cmd.mul_x)
        begin
            if (status.r1_zero)
                c1_reg <= 2'd0;
            else if (cross_reg > 0)
                c1_reg <= 2'd1;
            else if (cross_reg < 0)
                c1_reg <= 2'd3;
            else if (dot_full > 0)
                c1_reg <= 2'd0;
            else
                c1_reg <= 2'd2;
        end
    end

    assign status.unit_done = unit_done_reg;
    assign status.r_zero    = (r_reg == '0);
    assign status.r1_zero   = (r1_reg == '0);
    assign status.command   = command_reg;

    assign width     = width_reg;
    assign height    = height_reg;
    assign box_min_x = omin_x_reg;
    assign box_min_y = omin_y_reg;
    assign box_valid = ovalid_reg;
endmodule

// ----- rtl/lab_control.sv -----
// Controller: sequences one edge through the datapath and runs the handshakes.
module lab_control (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  lab_pkg::lab_status_t   status,
    output lab_pkg::lab_cmd_t      cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_SQ0   = 4'd2;
    localparam logic [3:0] S_W0    = 4'd3;
    localparam logic [3:0] S_SQ1   = 4'd4;
    localparam logic [3:0] S_W1    = 4'd5;
    localparam logic [3:0] S_MULX  = 4'd6;
    localparam logic [3:0] S_DIVX  = 4'd7;
    localparam logic [3:0] S_WX    = 4'd8;
    localparam logic [3:0] S_MULY  = 4'd9;
    localparam logic [3:0] S_DIVY  = 4'd10;
    localparam logic [3:0] S_WY    = 4'd11;
    localparam logic [3:0] S_END   = 4'd12;
    localparam logic [3:0] S_AXES  = 4'd13;
    localparam logic [3:0] S_PUB   = 4'd14;

    logic [3:0] state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    // A waiting result holds only the publish step; the input is stalled whenever the controller is not idle.
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (status.command == lab_pkg::CMD_LINE)
                begin
                    cmd.take_line = 1'b1;
                    state_next = S_PUB;
                end
                else if (status.command == lab_pkg::CMD_ARC)
                begin
                    cmd.take_start = 1'b1;
                    state_next = S_SQ0;
                end
                else
                    state_next = S_PUB;
            end
            S_SQ0:
            begin
                cmd.sq0 = 1'b1;
                state_next = S_W0;
            end
            S_W0:
                if (status.unit_done)
                    state_next = S_SQ1;
            S_SQ1:
            begin
                // The root is written on the cycle after done.
                if (status.r_zero)
                    state_next = S_PUB;
                else
                begin
                    cmd.sq1 = 1'b1;
                    state_next = S_W1;
                end
            end
            S_W1:
                if (status.unit_done)
                    state_next = S_MULX;
            S_MULX:
            begin
                cmd.mul_x = 1'b1;
                state_next = status.r1_zero ? S_AXES : S_DIVX;
            end
            S_DIVX:
            begin
                cmd.div_x = 1'b1;
                state_next = S_WX;
            end
            S_WX:
                if (status.unit_done)
                    state_next = S_MULY;
            S_MULY:
            begin
                cmd.mul_y = 1'b1;
                state_next = S_DIVY;
            end
            S_DIVY:
            begin
                cmd.div_y = 1'b1;
                state_next = S_WY;
            end
            S_WY:
                if (status.unit_done)
                    state_next = S_END;
            S_END:
            begin
                cmd.take_end = 1'b1;
                state_next = S_AXES;
            end
            S_AXES:
            begin
                cmd.take_axes = 1'b1;
                state_next = S_PUB;
            end
            S_PUB:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    cmd.publish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ----- rtl/line_arc_bounding_box.sv -----
// Top level of the running bounding box of line and arc path edges.
// One word is taken per edge and one result word comes back for it. A line or an
// unknown command goes from acceptance through dispatch to publish. An arc runs two
// radius square roots and two end point scaling divisions on one shared bit-serial
// root/divide unit, each COORD_WIDTH+1 steps long; a zero radius arc ends after its
// first root, and an arc whose end lies on the centre skips the divisions and the end
// point. The next word is taken on the cycle after a result is published. The result
// register lets a new word enter while the last result waits.
module line_arc_bounding_box #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     command,
    input  logic                           first_edge,
    input  logic signed [COORD_WIDTH-1:0]  start_x,
    input  logic signed [COORD_WIDTH-1:0]  start_y,
    input  logic signed [COORD_WIDTH-1:0]  end_x,
    input  logic signed [COORD_WIDTH-1:0]  end_y,
    input  logic signed [COORD_WIDTH-1:0]  center_x,
    input  logic signed [COORD_WIDTH-1:0]  center_y,
    input  logic                           second_is_cw_start,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [COORD_WIDTH-1:0]         width,
    output logic [COORD_WIDTH-1:0]         height,
    output logic signed [COORD_WIDTH-1:0]  box_min_x,
    output logic signed [COORD_WIDTH-1:0]  box_min_y,
    output logic                           box_valid
);
    lab_pkg::lab_cmd_t    cmd;
    lab_pkg::lab_status_t status;

    lab_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lab_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .command            (command),
        .first_edge         (first_edge),
        .start_x            (start_x),
        .start_y            (start_y),
        .end_x              (end_x),
        .end_y              (end_y),
        .center_x           (center_x),
        .center_y           (center_y),
        .second_is_cw_start (second_is_cw_start),
        .width              (width),
        .height             (height),
        .box_min_x          (box_min_x),
        .box_min_y          (box_min_y),
        .box_valid          (box_valid)
    );
endmodule
